@@ src/pmdh_pkg.sv @@
// Shared types, character codes and sizes for the pileup match-depth histogram.
`timescale 1ns / 1ps

package pmdh_pkg;

    // Histogram geometry: one 32-bit bin per (depth, match count) pair.
    localparam int BIN_W        = 32;
    localparam int AXIS_W       = 8;
    localparam int SLOT_W       = 2 * AXIS_W;
    localparam int HIST_ENTRIES = 1 << SLOT_W;

    // Line parser widths and limits.
    localparam int FIELD_W   = 3;
    localparam int DEPTH_W   = 17;
    localparam int PRODUCT_W = DEPTH_W + 4;
    localparam logic [DEPTH_W-1:0] DEPTH_SAT   = '1;
    localparam logic [FIELD_W-1:0] FIELD_SAT   = '1;
    localparam logic [FIELD_W-1:0] FIELD_DEPTH = 3'd3;
    localparam logic [FIELD_W-1:0] FIELD_BASES = 3'd4;

    // Match tally saturation point.
    localparam int MAX_DEPTH = 255;
    localparam int TALLY_CAP = (MAX_DEPTH < 255) ? MAX_DEPTH : 255;

    // Default depth of the queue between parser and histogram engine.
    localparam int QUEUE_DEPTH = 4;

    // Request command codes.
    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_MIN_DEPTH = 1'b0;
    localparam logic CFG_MAX_DEPTH = 1'b1;

    // Character codes.
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    // One histogram operation handed from the parser to the engine.
    typedef struct packed {
        logic              is_read;
        logic [SLOT_W-1:0] slot;
    } op_t;

endpackage

@@ src/pmdh_req_if.sv @@
// Request channel: pileup text bytes and bin read commands.
`timescale 1ns / 1ps

interface pmdh_req_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] text_byte;
    logic [7:0] query_depth;
    logic [7:0] query_matches;

    modport source (
        output valid, command, text_byte, query_depth, query_matches,
        input  ready
    );
    modport sink (
        input  valid, command, text_byte, query_depth, query_matches,
        output ready
    );
endinterface

@@ src/pmdh_rsp_if.sv @@
// Response channel: one histogram bin per read command.
`timescale 1ns / 1ps

interface pmdh_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] bin_total;
    logic [7:0]  bin_depth;
    logic [7:0]  bin_matches;

    modport source (
        output valid, bin_total, bin_depth, bin_matches,
        input  ready
    );
    modport sink (
        input  valid, bin_total, bin_depth, bin_matches,
        output ready
    );
endinterface

@@ src/pmdh_front.sv @@
// Front end: accepts requests, parses pileup lines and emits histogram operations.
`timescale 1ns / 1ps

module pmdh_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              enable,
    pmdh_req_if.sink          req,
    output logic              push,
    output pmdh_pkg::op_t     push_op
);

    logic [7:0]                     min_depth_reg;
    logic [7:0]                     max_depth_reg;
    logic [pmdh_pkg::FIELD_W-1:0]   field_number_reg, field_number_next;
    logic [pmdh_pkg::DEPTH_W-1:0]   depth_value_reg, depth_value_next;
    logic [7:0]                     match_tally_reg, match_tally_next;
    logic                           accept;
    logic                           is_digit;
    logic [7:0]                     digit_off;
    logic [pmdh_pkg::PRODUCT_W-1:0] depth_sum;
    logic                           line_counts;

    assign req.ready = enable;
    assign accept    = req.valid && enable;

    // Decimal accumulate of the depth field, one digit per byte.
    assign is_digit  = (req.text_byte >= pmdh_pkg::CHAR_ZERO) &&
                       (req.text_byte <= pmdh_pkg::CHAR_NINE);
    assign digit_off = req.text_byte - pmdh_pkg::CHAR_ZERO;
    assign depth_sum = pmdh_pkg::PRODUCT_W'({depth_value_reg, 3'b000})
                     + pmdh_pkg::PRODUCT_W'({depth_value_reg, 1'b0})
                     + pmdh_pkg::PRODUCT_W'(digit_off[3:0]);

    // A finished line counts when it had all five fields and its depth is in range.
    assign line_counts = (field_number_reg >= pmdh_pkg::FIELD_BASES) &&
                         (depth_value_reg >= pmdh_pkg::DEPTH_W'(min_depth_reg)) &&
                         (depth_value_reg <= pmdh_pkg::DEPTH_W'(max_depth_reg));

    // Line state update and operation emission.
    always_comb
    begin
        field_number_next = field_number_reg;
        depth_value_next  = depth_value_reg;
        match_tally_next  = match_tally_reg;
        push              = 1'b0;
        push_op.is_read   = 1'b0;
        push_op.slot      = {depth_value_reg[7:0], match_tally_reg};
        if (accept)
        begin
            if (req.command == pmdh_pkg::CMD_READ)
            begin
                push            = 1'b1;
                push_op.is_read = 1'b1;
                push_op.slot    = {req.query_depth, req.query_matches};
            end
            else
            begin
                priority if (req.text_byte == pmdh_pkg::CHAR_NEWLINE)
                begin
                    push              = line_counts;
                    field_number_next = '0;
                    depth_value_next  = '0;
                    match_tally_next  = '0;
                end
                else if (req.text_byte == pmdh_pkg::CHAR_TAB)
                begin
                    if (field_number_reg != pmdh_pkg::FIELD_SAT)
                    begin
                        field_number_next = field_number_reg + 1'b1;
                    end
                end
                else if (field_number_reg == pmdh_pkg::FIELD_DEPTH)
                begin
                    if (is_digit)
                    begin
                        if (depth_sum > pmdh_pkg::PRODUCT_W'(pmdh_pkg::DEPTH_SAT))
                        begin
                            depth_value_next = pmdh_pkg::DEPTH_SAT;
                        end
                        else
                        begin
                            depth_value_next = depth_sum[pmdh_pkg::DEPTH_W-1:0];
                        end
                    end
                end
                else if (field_number_reg == pmdh_pkg::FIELD_BASES)
                begin
                    if (((req.text_byte == pmdh_pkg::CHAR_COMMA) ||
                         (req.text_byte == pmdh_pkg::CHAR_DOT)) &&
                        (match_tally_reg < 8'(pmdh_pkg::TALLY_CAP)))
                    begin
                        match_tally_next = match_tally_reg + 1'b1;
                    end
                end
                else
                begin
                    field_number_next = field_number_reg;
                end
            end
        end
    end

    // Line state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_number_reg <= '0;
            depth_value_reg  <= '0;
            match_tally_reg  <= '0;
        end
        else
        begin
            field_number_reg <= field_number_next;
            depth_value_reg  <= depth_value_next;
            match_tally_reg  <= match_tally_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_depth_reg <= 8'd0;
            max_depth_reg <= 8'd255;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pmdh_pkg::CFG_MIN_DEPTH: min_depth_reg <= cfg_data;
                pmdh_pkg::CFG_MAX_DEPTH: max_depth_reg <= cfg_data;
                default:                 min_depth_reg <= min_depth_reg;
            endcase
        end
    end

endmodule

@@ src/pmdh_queue.sv @@
// Short operation queue between the parser and the histogram engine.
`timescale 1ns / 1ps

module pmdh_queue #(
    parameter int DEPTH = pmdh_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pmdh_pkg::op_t push_op,
    input  logic          pop,
    output logic          has_space,
    output logic          not_empty,
    output pmdh_pkg::op_t head_op
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pmdh_pkg::op_t    slots_reg [DEPTH];
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign has_space = (count_reg < CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_op   = slots_reg[head_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == IDX_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (pop)
        begin
            head_next = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[tail_reg] <= push_op;
        end
    end

endmodule

@@ src/pmdh_back.sv @@
// Histogram engine: bin memory, clearing pass, increment and read pipeline.
`timescale 1ns / 1ps

module pmdh_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  pmdh_pkg::op_t q_op,
    output logic          pop,
    output logic          busy,
    pmdh_rsp_if.source    rsp
);

    logic [pmdh_pkg::BIN_W-1:0]  mem [pmdh_pkg::HIST_ENTRIES];
    logic [pmdh_pkg::BIN_W-1:0]  rdata_reg;
    logic                        clear_active_reg, clear_active_next;
    logic [pmdh_pkg::SLOT_W-1:0] clear_addr_reg, clear_addr_next;
    logic                        b_valid_reg, b_valid_next;
    pmdh_pkg::op_t               b_op_reg;
    logic                        fwd_valid_reg;
    logic [pmdh_pkg::SLOT_W-1:0] fwd_slot_reg;
    logic [pmdh_pkg::BIN_W-1:0]  fwd_data_reg;
    logic                        rsp_valid_reg, rsp_valid_next;
    logic [pmdh_pkg::BIN_W-1:0]  rsp_total_reg;
    logic [pmdh_pkg::SLOT_W-1:0] rsp_slot_reg;
    logic                        stall_b;
    logic                        advance;
    logic                        fwd_hit;
    logic [pmdh_pkg::BIN_W-1:0]  cur_bin;
    logic [pmdh_pkg::BIN_W-1:0]  inc_bin;
    logic                        do_inc;
    logic                        load_rsp;
    logic                        mem_we;
    logic [pmdh_pkg::SLOT_W-1:0] mem_waddr;
    logic [pmdh_pkg::BIN_W-1:0]  mem_wdata;

    assign busy = clear_active_reg;

    // Pipeline control: only clearing or a read at a full rsp register stalls.
    assign stall_b  = b_valid_reg && b_op_reg.is_read && rsp_valid_reg && !rsp.ready;
    assign advance  = !clear_active_reg && !stall_b;
    assign pop      = advance && q_valid;
    assign b_valid_next = advance ? q_valid : b_valid_reg;

    // The bin written in the previous cycle is not yet visible in read data.
    assign fwd_hit  = fwd_valid_reg && (fwd_slot_reg == b_op_reg.slot);
    assign cur_bin  = fwd_hit ? fwd_data_reg : rdata_reg;
    assign inc_bin  = (&cur_bin) ? cur_bin : cur_bin + 1'b1;
    assign do_inc   = b_valid_reg && !b_op_reg.is_read;
    assign load_rsp = b_valid_reg && b_op_reg.is_read && !stall_b;

    // Memory write port is shared by the clearing pass and increments.
    assign mem_we    = clear_active_reg || do_inc;
    assign mem_waddr = clear_active_reg ? clear_addr_reg : b_op_reg.slot;
    assign mem_wdata = clear_active_reg ? '0 : inc_bin;

    // Clearing pass sequencing.
    always_comb
    begin
        clear_active_next = clear_active_reg;
        clear_addr_next   = clear_addr_reg;
        if (clear_active_reg)
        begin
            clear_addr_next = clear_addr_reg + 1'b1;
            if (&clear_addr_reg)
            begin
                clear_active_next = 1'b0;
            end
        end
    end

    // Response register valid tracking.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
            b_valid_reg      <= 1'b0;
            fwd_valid_reg    <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            clear_active_reg <= clear_active_next;
            clear_addr_reg   <= clear_addr_next;
            b_valid_reg      <= b_valid_next;
            rsp_valid_reg    <= rsp_valid_next;
            if (do_inc)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_op_reg <= q_op;
        end
        if (do_inc)
        begin
            fwd_slot_reg <= b_op_reg.slot;
            fwd_data_reg <= inc_bin;
        end
        if (load_rsp)
        begin
            rsp_total_reg <= cur_bin;
            rsp_slot_reg  <= b_op_reg.slot;
        end
    end

    // Bin memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (pop)
        begin
            rdata_reg <= mem[q_op.slot];
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.bin_total   = rsp_total_reg;
    assign rsp.bin_depth   = rsp_slot_reg[pmdh_pkg::SLOT_W-1:pmdh_pkg::AXIS_W];
    assign rsp.bin_matches = rsp_slot_reg[pmdh_pkg::AXIS_W-1:0];

    // Nothing leaves the queue while the memory is being cleared.
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_active_reg |-> !pop)
        else $error("operation popped during clearing pass");

    // The clearing pass never overlaps an operation in flight.
    a_no_op_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_active_reg |-> !b_valid_reg)
        else $error("operation in flight during clearing pass");

    // A new response only follows a read command in the engine stage.
    a_rsp_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(b_valid_reg && b_op_reg.is_read))
        else $error("response raised without a read command");

    // A stalled read keeps its place in the engine stage.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stall_b |=> (b_valid_reg && b_op_reg.is_read))
        else $error("stalled read lost from engine stage");

endmodule

@@ src/pileup_match_depth_histogram_top.sv @@
// Top level of the pileup match-depth histogram.
`timescale 1ns / 1ps

// Usage:
// The req channel carries one request per accepted handshake. Command text
// feeds one byte of tab-separated pileup text; command read asks for the bin
// at (query_depth, query_matches). Each finished line with all five fields and
// with depth in [min_depth, max_depth] adds one to its (depth, match count) bin,
// saturating. The rsp channel returns one bin for every read, in request order.
// Throughput is one request per cycle while the queue has space and no
// clearing pass runs: the parser takes a byte every cycle it is enabled and
// the histogram engine does one read-modify-write per cycle, unless rsp holds
// a read, on its bin memory, which has one read port and one write port, with
// a one-deep forward of the last written bin so back-to-back increments of the same bin stay exact.
// An accepted read passes through the queue, the engine stage and the response register before rsp.valid.
// After reset the engine clears all 65536 bins, one per cycle; req.ready stays
// low during the clearing pass, while configuration writes are taken as usual.
// When rsp stalls, the engine holds the pending read and the operation queue
// absorbs up to QUEUE_DEPTH operations (reads and counted lines) before
// req.ready drops.
// Configuration writes take effect on the next cycle; the user must make them while idle (not enforced).

module pileup_match_depth_histogram_top #(
    parameter int QUEUE_DEPTH = pmdh_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    pmdh_req_if.sink   req,
    pmdh_rsp_if.source rsp
);

    logic          push;
    pmdh_pkg::op_t push_op;
    logic          pop;
    logic          has_space;
    logic          not_empty;
    pmdh_pkg::op_t head_op;
    logic          busy;
    logic          front_enable;

    assign front_enable = has_space && !busy;

    pmdh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .enable    (front_enable),
        .req       (req),
        .push      (push),
        .push_op   (push_op)
    );

    pmdh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .pop       (pop),
        .has_space (has_space),
        .not_empty (not_empty),
        .head_op   (head_op)
    );

    pmdh_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (not_empty),
        .q_op    (head_op),
        .pop     (pop),
        .busy    (busy),
        .rsp     (rsp)
    );

endmodule
